### rtl/biquad_iir_filter_top_assert.svh
// ----------------------------------------------------------------------------
// Biquad IIR filter assertion macros
// Concurrent assertion wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BIQUAD_IIR_FILTER_TOP_ASSERT_SVH
`define BIQUAD_IIR_FILTER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// consequent must hold in the same cycle as the antecedent
`define BIQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("biquad assertion failed");

// consequent must hold in the cycle after the antecedent
`define BIQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("biquad assertion failed");

`else

`define BIQ_ASSERT_NOW(lbl, ante, cons)
`define BIQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/biq_pkg.sv
// ----------------------------------------------------------------------------
// Biquad IIR filter package
// Shared widths, defaults and register and operation codes.
// ----------------------------------------------------------------------------
package biq_pkg;

  localparam int SAMPLE_WIDTH_DEF    = 24;
  localparam int COEFF_FRAC_BITS_DEF = 22;
  localparam int COEFF_WIDTH         = 26;

  localparam int NUM_REGS   = 6;
  localparam int REG_IDX_W  = $clog2(NUM_REGS);
  localparam int CFG_ADDR_W = $clog2(4 * NUM_REGS);
  localparam int CFG_DATA_W = 32;

  localparam logic [REG_IDX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FF0    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FF1    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FF2    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FB1    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FB2    = 3'd5;

  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

endpackage

### rtl/biquad_iir_filter_top.sv
// ----------------------------------------------------------------------------
// Biquad IIR filter top level
// Direct form I biquad on signed samples with APB-style coefficient port.
// ----------------------------------------------------------------------------
// Takes one word per cycle and returns one result word per cycle while
// out_ready does not stall the result; a word passes the input register,
// then the result register. The rate is set by the feedback path in the
// input-register stage: the five coefficient products, their sum, rounding
// and range check are combinational, so the history is ready for the next
// word. A clear word zeroes the history and returns nothing. An out-of-range
// result returns zero with overflowed set and clears the history. Coefficients
// are signed, 26 bits, COEFF_FRAC_BITS fraction bits; write them only while the block is idle.

`include "biquad_iir_filter_top_assert.svh"

module biquad_iir_filter_top #(
  parameter int SAMPLE_WIDTH    = biq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEFF_FRAC_BITS = biq_pkg::COEFF_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_op,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_sample_in,

  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]     out_sample_out,
  output logic                               out_overflowed,

  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [biq_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [biq_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [biq_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);

  localparam int CW     = biq_pkg::COEFF_WIDTH;
  localparam int PROD_W = CW + SAMPLE_WIDTH;
  localparam int ACC_W  = PROD_W + 3;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (COEFF_FRAC_BITS - 1);

  // configuration
  logic                          enable_r;
  logic signed [CW-1:0]          ff0_r, ff1_r, ff2_r, fb1_r, fb2_r;
  logic [biq_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          cfg_wr;

  // input register
  logic                          s1_valid_r, s1_valid_nxt;
  logic                          s1_op_r;
  logic signed [SAMPLE_WIDTH-1:0] s1_x_r;
  logic                          s1_prod, s1_go, in_acc;

  // history
  logic signed [SAMPLE_WIDTH-1:0] x1_r, x1_nxt, x2_r, x2_nxt;
  logic signed [SAMPLE_WIDTH-1:0] y1_r, y1_nxt, y2_r, y2_nxt;

  // datapath
  logic signed [PROD_W-1:0]      p_ff0, p_ff1, p_ff2, p_fb1, p_fb2;
  logic signed [ACC_W-1:0]       acc, acc_rnd, y_full;
  logic                          y_ovf;
  logic signed [SAMPLE_WIDTH-1:0] y_res;

  // result register
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r, out_sample_nxt;
  logic                          out_ovf_r, out_ovf_nxt;

  assign reg_idx = paddr[biq_pkg::CFG_ADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign pready  = 1'b1;

  always_comb begin
    case (reg_idx)
      biq_pkg::REG_ENABLE: prdata = biq_pkg::CFG_DATA_W'(enable_r);
      biq_pkg::REG_FF0:    prdata = {{(biq_pkg::CFG_DATA_W-CW){ff0_r[CW-1]}}, ff0_r};
      biq_pkg::REG_FF1:    prdata = {{(biq_pkg::CFG_DATA_W-CW){ff1_r[CW-1]}}, ff1_r};
      biq_pkg::REG_FF2:    prdata = {{(biq_pkg::CFG_DATA_W-CW){ff2_r[CW-1]}}, ff2_r};
      biq_pkg::REG_FB1:    prdata = {{(biq_pkg::CFG_DATA_W-CW){fb1_r[CW-1]}}, fb1_r};
      biq_pkg::REG_FB2:    prdata = {{(biq_pkg::CFG_DATA_W-CW){fb2_r[CW-1]}}, fb2_r};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      ff0_r    <= '0;
      ff1_r    <= '0;
      ff2_r    <= '0;
      fb1_r    <= '0;
      fb2_r    <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        biq_pkg::REG_ENABLE: enable_r <= pwdata[0];
        biq_pkg::REG_FF0:    ff0_r    <= pwdata[CW-1:0];
        biq_pkg::REG_FF1:    ff1_r    <= pwdata[CW-1:0];
        biq_pkg::REG_FF2:    ff2_r    <= pwdata[CW-1:0];
        biq_pkg::REG_FB1:    fb1_r    <= pwdata[CW-1:0];
        biq_pkg::REG_FB2:    fb2_r    <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign s1_prod  = s1_valid_r & (s1_op_r == biq_pkg::OP_FILTER);
  assign s1_go    = s1_valid_r & (~s1_prod | ~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | s1_go;
  assign in_acc   = in_valid & in_ready;

  // filter datapath
  assign p_ff0 = ff0_r * s1_x_r;
  assign p_ff1 = ff1_r * x1_r;
  assign p_ff2 = ff2_r * x2_r;
  assign p_fb1 = fb1_r * y1_r;
  assign p_fb2 = fb2_r * y2_r;

  assign acc     = ACC_W'(p_ff0) + ACC_W'(p_ff1) + ACC_W'(p_ff2)
                 - ACC_W'(p_fb1) - ACC_W'(p_fb2);
  assign acc_rnd = acc + RND_HALF;
  assign y_full  = acc_rnd >>> COEFF_FRAC_BITS;
  assign y_ovf   = ~((&y_full[ACC_W-1:SAMPLE_WIDTH-1]) | ~(|y_full[ACC_W-1:SAMPLE_WIDTH-1]));
  assign y_res   = y_full[SAMPLE_WIDTH-1:0];

  always_comb begin
    s1_valid_nxt   = s1_valid_r;
    x1_nxt         = x1_r;
    x2_nxt         = x2_r;
    y1_nxt         = y1_r;
    y2_nxt         = y2_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_sample_nxt = out_sample_r;
    out_ovf_nxt    = out_ovf_r;

    if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end

    if (s1_go) begin
      if (!s1_prod) begin
        x1_nxt = '0;
        x2_nxt = '0;
        y1_nxt = '0;
        y2_nxt = '0;
      end else if (!enable_r) begin
        out_valid_nxt  = 1'b1;
        out_sample_nxt = s1_x_r;
        out_ovf_nxt    = 1'b0;
      end else if (y_ovf) begin
        x1_nxt         = '0;
        x2_nxt         = '0;
        y1_nxt         = '0;
        y2_nxt         = '0;
        out_valid_nxt  = 1'b1;
        out_sample_nxt = '0;
        out_ovf_nxt    = 1'b1;
      end else begin
        x2_nxt         = x1_r;
        x1_nxt         = s1_x_r;
        y2_nxt         = y1_r;
        y1_nxt         = y_res;
        out_valid_nxt  = 1'b1;
        out_sample_nxt = y_res;
        out_ovf_nxt    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      x1_r        <= '0;
      x2_r        <= '0;
      y1_r        <= '0;
      y2_r        <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      x1_r        <= x1_nxt;
      x2_r        <= x2_nxt;
      y1_r        <= y1_nxt;
      y2_r        <= y2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r <= in_op;
      s1_x_r  <= in_sample_in;
    end
    out_sample_r <= out_sample_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_overflowed = out_ovf_r;

  // overflow word carries a zero sample
  `BIQ_ASSERT_NOW(a_ovf_zero, out_valid_r && out_ovf_r, out_sample_r == '0)
  // a waiting filter word is never overwritten while the result is stalled
  `BIQ_ASSERT_NOW(a_no_overrun, s1_prod && out_valid_r && !out_ready, !in_ready)
  // a clear word leaves an empty history
  `BIQ_ASSERT_NEXT(a_clear_hist, s1_go && !s1_prod,
                   x1_r == '0 && x2_r == '0 && y1_r == '0 && y2_r == '0)

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// Biquad IIR filter testbench
// Drives sample and clear words into the filter over a valid/ready channel,
// programs the coefficients over the APB-style port between phases and checks
// every result word against a cycle-free model of the direct form I biquad.
// Directed corner cases come first, then random phases under several
// coefficient settings with random idling on both channels in all phases but one.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW             = biq_pkg::SAMPLE_WIDTH_DEF;
  localparam int FRAC           = biq_pkg::COEFF_FRAC_BITS_DEF;
  localparam int CW             = biq_pkg::COEFF_WIDTH;
  localparam int IDX_W          = biq_pkg::REG_IDX_W;
  localparam int DW             = biq_pkg::CFG_DATA_W;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 6;
  localparam int MAX_REPORTS    = 10;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_WORDS    = 230;

  localparam logic signed [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};

  localparam logic signed [CW-1:0] CF_MAX  = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CF_MIN  = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] CF_ONE  = CW'(1 << FRAC);
  localparam logic signed [CW-1:0] CF_HALF = CW'(1 << (FRAC - 1));

  // addresses past the register file
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [SW-1:0] smp;
    logic                 ovf;
  } filt_word_t;

  logic                            clk          = 1'b0;
  logic                            rst_n        = 1'b0;
  logic                            in_valid     = 1'b0;
  logic                            in_op        = biq_pkg::OP_FILTER;
  logic signed [SW-1:0]            in_sample_in = '0;
  logic                            out_ready    = 1'b0;
  logic                            psel         = 1'b0;
  logic                            penable      = 1'b0;
  logic                            pwrite       = 1'b0;
  logic [biq_pkg::CFG_ADDR_W-1:0]  paddr        = '0;
  logic [DW-1:0]                   pwdata       = '0;
  logic                            in_ready;
  logic                            out_valid;
  logic signed [SW-1:0]            out_sample_out;
  logic                            out_overflowed;
  logic [DW-1:0]                   prdata;
  logic                            pready;

  filt_word_t pending_words[$];

  logic                          flt_en;
  logic signed [CW-1:0]          coeff_reg [biq_pkg::NUM_REGS];
  logic signed [SW-1:0]          hist_x1, hist_x2, hist_y1, hist_y2;

  int  mismatch_cnt  = 0;
  int  words_sent    = 0;
  int  words_checked = 0;
  int  ovf_seen      = 0;
  int  idle_cycles   = 0;
  bit  gaps_on       = 1'b1;

  biquad_iir_filter_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_overflowed (out_overflowed),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #1 clk = ~clk;

  function automatic void clear_hist();
    hist_x1 = '0;
    hist_x2 = '0;
    hist_y1 = '0;
    hist_y2 = '0;
  endfunction

  function automatic void filter_sample(input logic op, input logic signed [SW-1:0] smp);
    longint     acc;
    longint     y;
    filt_word_t w;
    if (op == biq_pkg::OP_CLEAR) begin
      clear_hist();
      return;
    end
    w.smp = smp;
    w.ovf = 1'b0;
    if (flt_en) begin
      acc = longint'(coeff_reg[biq_pkg::REG_FF0]) * longint'(smp)
          + longint'(coeff_reg[biq_pkg::REG_FF1]) * longint'(hist_x1)
          + longint'(coeff_reg[biq_pkg::REG_FF2]) * longint'(hist_x2)
          - longint'(coeff_reg[biq_pkg::REG_FB1]) * longint'(hist_y1)
          - longint'(coeff_reg[biq_pkg::REG_FB2]) * longint'(hist_y2);
      // round half up, then floor
      y = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
      if (y > longint'(SMP_MAX) || y < longint'(SMP_MIN)) begin
        clear_hist();
        w.smp = '0;
        w.ovf = 1'b1;
      end else begin
        hist_x2 = hist_x1;
        hist_x1 = smp;
        hist_y2 = hist_y1;
        hist_y1 = y[SW-1:0];
        w.smp   = y[SW-1:0];
      end
    end
    pending_words.push_back(w);
  endfunction

  function automatic logic signed [SW-1:0] rand_sample();
    int v;
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
      1, 2: begin
        v = int'($urandom_range(0, 512)) - 256;
        return v[SW-1:0];
      end
      default: return SW'($urandom());
    endcase
  endfunction

  function automatic logic signed [CW-1:0] rand_coeff();
    int v;
    case ($urandom_range(0, 5))
      0: return CW'($urandom());
      1: return CF_MAX;
      2: return CF_MIN;
      default: begin
        v = int'($urandom_range(0, 1 << FRAC)) - (1 << (FRAC - 1));
        return v[CW-1:0];
      end
    endcase
  endfunction

  task automatic send_word(input logic op, input logic signed [SW-1:0] smp);
    while (gaps_on && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_sample_in <= smp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    filter_sample(op, smp);
    words_sent++;
  endtask

  // lets the pipeline empty, clear words included
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      biq_pkg::REG_ENABLE: flt_en = val[0];
      biq_pkg::REG_FF0, biq_pkg::REG_FF1, biq_pkg::REG_FF2,
      biq_pkg::REG_FB1, biq_pkg::REG_FB2: coeff_reg[idx] = val[CW-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_config(input logic en,
                             input logic signed [CW-1:0] ff0, ff1, ff2, fb1, fb2);
    cfg_write(biq_pkg::REG_ENABLE, {{(DW-1){1'b0}}, en});
    cfg_write(biq_pkg::REG_FF0, DW'(ff0));
    cfg_write(biq_pkg::REG_FF1, DW'(ff1));
    cfg_write(biq_pkg::REG_FF2, DW'(ff2));
    cfg_write(biq_pkg::REG_FB1, DW'(fb1));
    cfg_write(biq_pkg::REG_FB2, DW'(fb2));
  endtask

  task automatic test_passthrough();
    send_word(biq_pkg::OP_FILTER, SMP_MIN);
    send_word(biq_pkg::OP_FILTER, SMP_MAX);
    send_word(biq_pkg::OP_FILTER, '0);
    send_word(biq_pkg::OP_FILTER, -1);
  endtask

  task automatic test_rounding();
    wait_idle();
    load_config(1'b1, CF_ONE, '0, '0, '0, '0);
    send_word(biq_pkg::OP_FILTER, SMP_MAX);
    send_word(biq_pkg::OP_FILTER, SMP_MIN);
    wait_idle();
    // half gain: odd inputs land exactly on ties
    load_config(1'b1, CF_HALF, '0, '0, '0, '0);
    send_word(biq_pkg::OP_FILTER, 1);
    send_word(biq_pkg::OP_FILTER, -1);
    send_word(biq_pkg::OP_FILTER, 3);
    send_word(biq_pkg::OP_FILTER, -3);
  endtask

  task automatic test_overflow();
    wait_idle();
    load_config(1'b1, CF_MAX, '0, '0, '0, '0);
    send_word(biq_pkg::OP_FILTER, SMP_MAX);
    send_word(biq_pkg::OP_FILTER, SMP_MIN);
    wait_idle();
    // second word overflows; third shows the history was dropped
    load_config(1'b1, CF_ONE, CF_ONE, '0, '0, '0);
    send_word(biq_pkg::OP_FILTER, SMP_MAX);
    send_word(biq_pkg::OP_FILTER, 1);
    send_word(biq_pkg::OP_FILTER, 5);
  endtask

  task automatic test_clear();
    wait_idle();
    load_config(1'b1, CF_ONE, CF_HALF, CF_HALF, -CF_HALF, CF_HALF);
    send_word(biq_pkg::OP_FILTER, 1000);
    send_word(biq_pkg::OP_FILTER, 2000);
    send_word(biq_pkg::OP_CLEAR, SMP_MAX);
    send_word(biq_pkg::OP_FILTER, 7);
    wait_idle();
    cfg_write(biq_pkg::REG_ENABLE, '0);
    send_word(biq_pkg::OP_FILTER, 100);
    send_word(biq_pkg::OP_CLEAR, SMP_MIN);
    wait_idle();
    cfg_write(biq_pkg::REG_ENABLE, {{(DW-1){1'b0}}, 1'b1});
    send_word(biq_pkg::OP_FILTER, 9);
  endtask

  task automatic test_register_decode();
    wait_idle();
    cfg_write(biq_pkg::REG_ENABLE, '1);
    cfg_write(biq_pkg::REG_FF0, {6'h2a, CF_ONE});
    cfg_write(REG_SPARE_LO, '1);
    cfg_write(REG_SPARE_HI, '1);
    send_word(biq_pkg::OP_FILTER, 77);
    send_word(biq_pkg::OP_FILTER, -77);
  endtask

  task automatic test_random();
    int ph;
    int n;
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: load_config(1'b0, rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff(),
                       rand_coeff());
        2: load_config(1'b1, CF_MAX, CF_MAX, CF_MAX, CF_MAX, CF_MAX);
        3: load_config(1'b1, CF_MIN, CF_MIN, CF_MIN, CF_MIN, CF_MIN);
        6: load_config(1'b1, CF_ONE >>> 2, CF_HALF, CF_ONE >>> 2, -CF_HALF, CF_ONE >>> 3);
        default: load_config(1'b1, rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff(),
                             rand_coeff());
      endcase
      gaps_on = (ph != 4);
      for (n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 99) < 3) send_word(biq_pkg::OP_CLEAR, rand_sample());
        else send_word(biq_pkg::OP_FILTER, rand_sample());
      end
    end
    gaps_on = 1'b1;
    wait_idle();
  endtask

  always @(posedge clk) begin : result_check
    filt_word_t want;
    out_ready <= !(gaps_on && $urandom_range(0, 99) < 12);
    if (rst_n && out_valid && out_ready) begin
      words_checked++;
      if (out_overflowed) ovf_seen++;
      if (pending_words.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("%0t: unexpected word, sample %0d overflowed %0b",
                   $time, out_sample_out, out_overflowed);
      end else begin
        want = pending_words.pop_front();
        if (out_sample_out !== want.smp || out_overflowed !== want.ovf) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t: sample exp %0d got %0d, overflowed exp %0b got %0b",
                     $time, want.smp, out_sample_out, want.ovf, out_overflowed);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clear_hist();
    flt_en = 1'b0;
    foreach (coeff_reg[i]) coeff_reg[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_passthrough();
    test_rounding();
    test_overflow();
    test_clear();
    test_register_decode();
    test_random();
    $display("%0d words sent, %0d results checked, %0d overflowed, %0d mismatches",
             words_sent, words_checked, ovf_seen, mismatch_cnt);
    $display("covered pass-through, rounding ties, overflow, clears and %0d random phases",
             RAND_PHASES);
    if (mismatch_cnt == 0 && pending_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/biq_pkg.sv
rtl/biquad_iir_filter_top.sv
test/tb.sv
